/* hdl/ftm_pkg.sv */
// shared types, opcodes and field widths of the frame timing monitor
package ftm_pkg;

  // field widths of the request and result items
  localparam int unsigned OP_W       = 4;
  localparam int unsigned TS_W       = 48;
  localparam int unsigned TOTAL_W    = 64;
  localparam int unsigned STAT_W     = 32;
  localparam int unsigned OUT_DATA_W = 7 * STAT_W + TS_W;

  // event opcodes
  localparam logic [OP_W-1:0] OP_FRAME_START  = 4'd0;
  localparam logic [OP_W-1:0] OP_FRAME_END    = 4'd1;
  localparam logic [OP_W-1:0] OP_RENDER_START = 4'd2;
  localparam logic [OP_W-1:0] OP_RENDER_END   = 4'd3;
  localparam logic [OP_W-1:0] OP_FLUSH_START  = 4'd4;
  localparam logic [OP_W-1:0] OP_FLUSH_END    = 4'd5;
  localparam logic [OP_W-1:0] OP_WAIT_START   = 4'd6;
  localparam logic [OP_W-1:0] OP_WAIT_END     = 4'd7;
  localparam logic [OP_W-1:0] OP_REPORT       = 4'd8;

  // which total goes through the shared divider
  localparam logic [1:0] DIV_RENDER = 2'd0;
  localparam logic [1:0] DIV_FLUSH  = 2'd1;
  localparam logic [1:0] DIV_SYNC   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       div_start;
    logic       q_store;
    logic       load_out;
    logic [1:0] div_sel;
  } ftm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_report;
    logic div_done;
  } ftm_sts_t;

endpackage

/* hdl/ftm_div.sv */
// iterative restoring divider, one quotient bit per cycle, 64 by 32 bits
module ftm_div import ftm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TOTAL_W-1:0] dividend,
  input  logic [STAT_W-1:0]  divisor,
  output logic               done,
  output logic [STAT_W-1:0]  quotient
);

  localparam int unsigned STEPS = TOTAL_W;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STAT_W-1:0]  rem_r, rem_nxt;
  logic [STAT_W-1:0]  dvs_r, dvs_nxt;
  logic [TOTAL_W-1:0] quo_r, quo_nxt;

  logic [STAT_W:0]   shifted;
  logic [STAT_W+1:0] trial;
  logic              fits;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_r, quo_r[TOTAL_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = !trial[STAT_W+1];
  end

  // step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[STAT_W-1:0] : shifted[STAT_W-1:0];
      quo_nxt = {quo_r[TOTAL_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[STAT_W-1:0];

endmodule

/* hdl/ftm_dp.sv */
// datapath: time marks, accumulators, divider and result register
module ftm_dp import ftm_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ftm_cmd_t              cmd,
  output ftm_sts_t              sts,
  input  logic [OP_W-1:0]       in_op,
  input  logic [TS_W-1:0]       in_ts,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int unsigned TW = TIME_WIDTH;

  // captured request
  logic [OP_W-1:0]    op_r;
  logic [TW-1:0]      now_r;
  logic [TOTAL_W-1:0] diff_r;

  // time marks
  logic [TW-1:0] frame_start_r, frame_start_nxt;
  logic [TW-1:0] frame_end_r, frame_end_nxt;
  logic [TW-1:0] sync_start_r, sync_start_nxt;
  logic [TW-1:0] render_start_r, render_start_nxt;
  logic [TW-1:0] flush_start_r, flush_start_nxt;
  logic [TW-1:0] wait_start_r, wait_start_nxt;
  logic [TW-1:0] last_report_r, last_report_nxt;
  logic          in_frame_r, in_frame_nxt;

  // accumulators
  logic [TOTAL_W-1:0] render_blocked_r, render_blocked_nxt;
  logic [TOTAL_W-1:0] render_total_r, render_total_nxt;
  logic [TOTAL_W-1:0] flush_total_r, flush_total_nxt;
  logic [TOTAL_W-1:0] sync_total_r, sync_total_nxt;
  logic [STAT_W-1:0]  frame_work_r, frame_work_nxt;
  logic [STAT_W-1:0]  frames_acc_r, frames_acc_nxt;
  logic [STAT_W-1:0]  render_samples_r, render_samples_nxt;
  logic [STAT_W-1:0]  max_frame_r, max_frame_nxt;
  logic [STAT_W-1:0]  max_work_r, max_work_nxt;
  logic [STAT_W-1:0]  max_gap_r, max_gap_nxt;

  // quotients and result register
  logic [STAT_W-1:0]     q_r [3];
  logic [OUT_DATA_W-1:0] out_r;

  logic [TW-1:0]      now_in;
  logic [TW-1:0]      mark;
  logic [TOTAL_W-1:0] render_net;
  logic [STAT_W-1:0]  diff_lo;
  logic [TOTAL_W-1:0] div_dividend;
  logic [STAT_W-1:0]  div_q;
  logic               div_done;
  logic [STAT_W-1:0]  avg [3];

  // timestamp taken modulo the time width
  assign now_in = TW'(TOTAL_W'(in_ts));

  // mark that the incoming event measures against
  always_comb begin
    case (in_op)
      OP_FRAME_START: mark = frame_end_r;
      OP_FRAME_END:   mark = frame_start_r;
      OP_RENDER_START: mark = sync_start_r;
      OP_RENDER_END:  mark = render_start_r;
      OP_FLUSH_END:   mark = flush_start_r;
      OP_WAIT_END:    mark = wait_start_r;
      default:        mark = last_report_r;
    endcase
  end

  // capture the request and its time difference
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      now_r  <= now_in;
      diff_r <= TOTAL_W'(now_in) - TOTAL_W'(mark);
    end
  end

  assign diff_lo    = diff_r[STAT_W-1:0];
  assign render_net = (diff_r > render_blocked_r) ? diff_r - render_blocked_r : '0;

  // state update for one event, or clear after a report
  always_comb begin
    frame_start_nxt    = frame_start_r;
    frame_end_nxt      = frame_end_r;
    sync_start_nxt     = sync_start_r;
    render_start_nxt   = render_start_r;
    flush_start_nxt    = flush_start_r;
    wait_start_nxt     = wait_start_r;
    last_report_nxt    = last_report_r;
    in_frame_nxt       = in_frame_r;
    render_blocked_nxt = render_blocked_r;
    render_total_nxt   = render_total_r;
    flush_total_nxt    = flush_total_r;
    sync_total_nxt     = sync_total_r;
    frame_work_nxt     = frame_work_r;
    frames_acc_nxt     = frames_acc_r;
    render_samples_nxt = render_samples_r;
    max_frame_nxt      = max_frame_r;
    max_work_nxt       = max_work_r;
    max_gap_nxt        = max_gap_r;
    if (cmd.exec) begin
      case (op_r)
        OP_FRAME_START: begin
          in_frame_nxt    = 1'b1;
          frame_start_nxt = now_r;
          sync_start_nxt  = now_r;
          frame_work_nxt  = '0;
          if (frame_end_r != '0 && diff_lo > max_gap_r) begin
            max_gap_nxt = diff_lo;
          end
        end
        OP_FRAME_END: begin
          if (in_frame_r) begin
            frames_acc_nxt = frames_acc_r + 1'b1;
            in_frame_nxt   = 1'b0;
            frame_end_nxt  = now_r;
            if (diff_lo > max_frame_r) begin
              max_frame_nxt = diff_lo;
            end
            if (frame_work_r > max_work_r) begin
              max_work_nxt = frame_work_r;
            end
          end
        end
        OP_RENDER_START: begin
          if (sync_start_r != '0) begin
            sync_total_nxt = sync_total_r + diff_r;
            frame_work_nxt = frame_work_r + diff_lo;
            sync_start_nxt = '0;
          end
          render_start_nxt   = now_r;
          render_blocked_nxt = '0;
        end
        OP_RENDER_END: begin
          if (render_start_r != '0) begin
            render_total_nxt   = render_total_r + render_net;
            frame_work_nxt     = frame_work_r + render_net[STAT_W-1:0];
            render_samples_nxt = render_samples_r + 1'b1;
            render_start_nxt   = '0;
            render_blocked_nxt = '0;
          end
        end
        OP_FLUSH_START: flush_start_nxt = now_r;
        OP_FLUSH_END: begin
          if (flush_start_r != '0) begin
            flush_total_nxt = flush_total_r + diff_r;
            if (render_start_r != '0) begin
              render_blocked_nxt = render_blocked_r + diff_r;
            end
            flush_start_nxt = '0;
          end
        end
        OP_WAIT_START: wait_start_nxt = now_r;
        OP_WAIT_END: begin
          if (wait_start_r != '0) begin
            flush_total_nxt = flush_total_r + diff_r;
            if (render_start_r != '0) begin
              render_blocked_nxt = render_blocked_r + diff_r;
            end
            wait_start_nxt = '0;
          end
        end
        default: ;
      endcase
    end else if (cmd.load_out) begin
      last_report_nxt    = now_r;
      frames_acc_nxt     = '0;
      render_total_nxt   = '0;
      render_samples_nxt = '0;
      flush_total_nxt    = '0;
      sync_total_nxt     = '0;
      max_frame_nxt      = '0;
      max_work_nxt       = '0;
      max_gap_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r    <= '0;
      frame_end_r      <= '0;
      sync_start_r     <= '0;
      render_start_r   <= '0;
      flush_start_r    <= '0;
      wait_start_r     <= '0;
      last_report_r    <= '0;
      in_frame_r       <= 1'b0;
      render_blocked_r <= '0;
      render_total_r   <= '0;
      flush_total_r    <= '0;
      sync_total_r     <= '0;
      frame_work_r     <= '0;
      frames_acc_r     <= '0;
      render_samples_r <= '0;
      max_frame_r      <= '0;
      max_work_r       <= '0;
      max_gap_r        <= '0;
    end else begin
      frame_start_r    <= frame_start_nxt;
      frame_end_r      <= frame_end_nxt;
      sync_start_r     <= sync_start_nxt;
      render_start_r   <= render_start_nxt;
      flush_start_r    <= flush_start_nxt;
      wait_start_r     <= wait_start_nxt;
      last_report_r    <= last_report_nxt;
      in_frame_r       <= in_frame_nxt;
      render_blocked_r <= render_blocked_nxt;
      render_total_r   <= render_total_nxt;
      flush_total_r    <= flush_total_nxt;
      sync_total_r     <= sync_total_nxt;
      frame_work_r     <= frame_work_nxt;
      frames_acc_r     <= frames_acc_nxt;
      render_samples_r <= render_samples_nxt;
      max_frame_r      <= max_frame_nxt;
      max_work_r       <= max_work_nxt;
      max_gap_r        <= max_gap_nxt;
    end
  end

  // dividend select for the shared divider
  always_comb begin
    case (cmd.div_sel)
      DIV_RENDER: div_dividend = render_total_r;
      DIV_FLUSH:  div_dividend = flush_total_r;
      default:    div_dividend = sync_total_r;
    endcase
  end

  ftm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (render_samples_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // keep each quotient as it finishes
  always_ff @(posedge clk) begin
    if (cmd.q_store) begin
      q_r[cmd.div_sel] <= div_q;
    end
  end

  // averages read zero when there was no render
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      avg[i] = (render_samples_r == '0) ? '0 : q_r[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= {diff_r[TS_W-1:0], max_gap_r, max_work_r, max_frame_r,
                avg[DIV_SYNC], avg[DIV_FLUSH], avg[DIV_RENDER], frames_acc_r};
    end
  end

  assign out_data      = out_r;
  assign sts.is_report = (op_r == OP_REPORT);
  assign sts.div_done  = div_done;

endmodule

/* hdl/ftm_ctrl.sv */
// controller: request sequencing, division steps and result handshake
module ftm_ctrl import ftm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ftm_sts_t sts,
  output ftm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_report) begin
          sel_nxt   = DIV_RENDER;
          state_nxt = S_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = sel_r;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_sel = sel_r;
        if (sts.div_done) begin
          cmd.q_store = 1'b1;
          if (sel_r == DIV_SYNC) begin
            state_nxt = S_DONE;
          end else begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= DIV_RENDER;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // divider finishes only while the controller waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV))
    else $error("divider done outside division wait");

  // a report starts the first division right after its update cycle
  a_report_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.is_report) |=> (cmd.div_start && cmd.div_sel == DIV_RENDER))
    else $error("report did not start the divider");

  // a loaded result is offered and the input reopens
  a_load_then_offer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_valid_r && in_tready))
    else $error("result load did not present the result");

endmodule

/* hdl/frame_timing_monitor_unit.sv */
// frame timing monitor: event timing statistics with periodic report
//
// Input channel in_*: one timestamped event per request, kind in in_tuser,
// time in in_tdata. Result channel out_*: one request per report event with
// counts, per-render averages, maxima and the interval since the last report.
// Ordinary events take a capture step, then an update step; in_tready is high
// again on the cycle after the update. Before a report's result is loaded,
// the three averages go one by one through a shared restoring divider that
// produces one quotient bit per cycle over 64 steps, plus a start step and a
// done step per division. The result sits in an output register; while it
// waits, the block goes on accepting ordinary events. A second report holds
// in the final load step until the previous result has been taken, stalling
// the input meanwhile. Reset clears all time marks, accumulators and the
// result valid flag; the first report measures its interval from time zero.
module frame_timing_monitor_unit import ftm_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TS_W-1:0]       in_tdata,   // timestamp_us
  input  logic [OP_W-1:0]       in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // frame_count, avg_render_us, avg_flush_us, avg_sync_us, max_frame_us,
  // max_work_us, max_gap_us (32 bits each), interval_us (48 bits)
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ftm_cmd_t cmd;
  ftm_sts_t sts;

  ftm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ftm_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (in_tuser),
    .in_ts    (in_tdata),
    .out_data (out_tdata)
  );

endmodule

/* verif/frame_timing_monitor_unit_tb.sv */
// testbench for frame_timing_monitor_unit: directed and random event streams
module frame_timing_monitor_unit_tb import ftm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_REPORT + 1'b1;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = {OP_W{1'b1}};

  // time allowed for a report: start, three divisions, load
  localparam int REPORT_CYCLES = 3 + 3 * 66;
  localparam int LIMIT_CYCLES  = 400000;

  // one report, laid out like out_tdata (frame_count in the low bits)
  typedef struct packed {
    logic [TS_W-1:0]   interval_us;
    logic [STAT_W-1:0] max_gap_us;
    logic [STAT_W-1:0] max_work_us;
    logic [STAT_W-1:0] max_frame_us;
    logic [STAT_W-1:0] avg_sync_us;
    logic [STAT_W-1:0] avg_flush_us;
    logic [STAT_W-1:0] avg_render_us;
    logic [STAT_W-1:0] frame_count;
  } frame_report_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [TS_W-1:0]       in_tdata   = '0;   // timestamp_us
  logic [OP_W-1:0]       in_tuser   = '0;   // op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // frame_count, avg_render_us, avg_flush_us, avg_sync_us, max_frame_us,
  // max_work_us, max_gap_us (32 bits each), interval_us (48 bits)
  logic [OUT_DATA_W-1:0] out_tdata;

  frame_report_t pending_reports[$];
  int            mismatches    = 0;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            events_sent   = 0;
  int            reports_sent  = 0;
  logic [TS_W-1:0] now_us      = '0;

  // predicted block state
  logic [TS_W-1:0]    mark_frame_start, mark_frame_end, mark_sync;
  logic [TS_W-1:0]    mark_render, mark_flush, mark_wait, last_report_ts;
  logic [TOTAL_W-1:0] work_this_frame, render_stall;
  logic [TOTAL_W-1:0] render_sum, flush_sum, sync_sum;
  logic               frame_open;
  logic [STAT_W-1:0]  frames_done, render_cnt, peak_frame, peak_work, peak_gap;

  frame_timing_monitor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // difference of two marks, wrapping at 64 bits
  function automatic logic [TOTAL_W-1:0] elapsed(logic [TS_W-1:0] now, logic [TS_W-1:0] mark);
    return TOTAL_W'(now) - TOTAL_W'(mark);
  endfunction

  function automatic logic [STAT_W-1:0] per_render(logic [TOTAL_W-1:0] total,
                                                   logic [STAT_W-1:0] n);
    if (n == '0) return '0;
    return STAT_W'(total / TOTAL_W'(n));
  endfunction

  function automatic void clear_stats();
    frames_done = '0;
    render_sum  = '0;
    render_cnt  = '0;
    flush_sum   = '0;
    sync_sum    = '0;
    peak_frame  = '0;
    peak_work   = '0;
    peak_gap    = '0;
  endfunction

  function automatic void reset_stats();
    mark_frame_start = '0;
    mark_frame_end   = '0;
    mark_sync        = '0;
    mark_render      = '0;
    mark_flush       = '0;
    mark_wait        = '0;
    work_this_frame  = '0;
    render_stall     = '0;
    last_report_ts   = '0;
    frame_open       = 1'b0;
    clear_stats();
  endfunction

  // flush or wait interval closing; time overlapping an open render is blocked time
  function automatic void close_blocking(logic [TS_W-1:0] mark, logic [TS_W-1:0] now);
    logic [TOTAL_W-1:0] d;
    d = elapsed(now, mark);
    flush_sum = flush_sum + d;
    if (mark_render != '0) render_stall = render_stall + d;
  endfunction

  // advance the predicted statistics by one accepted event
  function automatic void update_timing_stats(logic [OP_W-1:0] op, logic [TS_W-1:0] now);
    logic [TOTAL_W-1:0] d;
    logic [STAT_W-1:0]  v;
    frame_report_t      r;
    case (op)
      OP_FRAME_START: begin
        frame_open       = 1'b1;
        mark_frame_start = now;
        mark_sync        = now;
        work_this_frame  = '0;
        if (mark_frame_end != '0) begin
          v = STAT_W'(elapsed(now, mark_frame_end));
          if (v > peak_gap) peak_gap = v;
        end
      end
      OP_FRAME_END: begin
        if (frame_open) begin
          frames_done    = frames_done + 1'b1;
          frame_open     = 1'b0;
          mark_frame_end = now;
          v = STAT_W'(elapsed(now, mark_frame_start));
          if (v > peak_frame) peak_frame = v;
          v = STAT_W'(work_this_frame);
          if (v > peak_work) peak_work = v;
        end
      end
      OP_RENDER_START: begin
        if (mark_sync != '0) begin
          d = elapsed(now, mark_sync);
          sync_sum        = sync_sum + d;
          work_this_frame = work_this_frame + d;
          mark_sync       = '0;
        end
        mark_render  = now;
        render_stall = '0;
      end
      OP_RENDER_END: begin
        if (mark_render != '0) begin
          d = elapsed(now, mark_render);
          d = (d > render_stall) ? d - render_stall : '0;
          render_sum      = render_sum + d;
          work_this_frame = work_this_frame + d;
          render_cnt      = render_cnt + 1'b1;
          mark_render     = '0;
          render_stall    = '0;
        end
      end
      OP_FLUSH_START: mark_flush = now;
      OP_FLUSH_END: begin
        if (mark_flush != '0) begin
          close_blocking(mark_flush, now);
          mark_flush = '0;
        end
      end
      OP_WAIT_START: mark_wait = now;
      OP_WAIT_END: begin
        if (mark_wait != '0) begin
          close_blocking(mark_wait, now);
          mark_wait = '0;
        end
      end
      OP_REPORT: begin
        r.frame_count   = frames_done;
        r.avg_render_us = per_render(render_sum, render_cnt);
        r.avg_flush_us  = per_render(flush_sum, render_cnt);
        r.avg_sync_us   = per_render(sync_sum, render_cnt);
        r.max_frame_us  = peak_frame;
        r.max_work_us   = peak_work;
        r.max_gap_us    = peak_gap;
        r.interval_us   = now - last_report_ts;
        pending_reports.push_back(r);
        last_report_ts = now;
        clear_stats();
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  function automatic void check_report(frame_report_t got);
    frame_report_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t unexpected report expected none actual %0h", $time, got);
      mismatches++;
      return;
    end
    want = pending_reports.pop_front();
    compare_field("frame_count", want.frame_count, got.frame_count);
    compare_field("avg_render_us", want.avg_render_us, got.avg_render_us);
    compare_field("avg_flush_us", want.avg_flush_us, got.avg_flush_us);
    compare_field("avg_sync_us", want.avg_sync_us, got.avg_sync_us);
    compare_field("max_frame_us", want.max_frame_us, got.max_frame_us);
    compare_field("max_work_us", want.max_work_us, got.max_work_us);
    compare_field("max_gap_us", want.max_gap_us, got.max_gap_us);
    compare_field("interval_us", want.interval_us, got.interval_us);
  endfunction

  // result side: check each accepted request, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_report(out_tdata);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // one event request, held until accepted; valid stays up for a back-to-back request
  task automatic send_event(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ts;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    update_timing_stats(op, ts);
    if (op <= OP_REPORT) events_sent++;
    if (op == OP_REPORT) reports_sent++;
  endtask

  // mostly short steps, now and then a long one past 32 bits
  function automatic logic [TS_W-1:0] advance_clock();
    logic [TS_W-1:0] step;
    if ($urandom_range(15) == 0)
      step = TS_W'({$urandom, $urandom} >> $urandom_range(16, 30));
    else
      step = TS_W'($urandom_range(1, 3000));
    now_us = now_us + step;
    return now_us;
  endfunction

  function automatic logic [TS_W-1:0] noise_time();
    if ($urandom_range(1) == 0) return advance_clock();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // well-formed frame: sync, one or two renders, each with any flush or wait intervals inside
  task automatic send_frame();
    int   renders;
    int   blocks;
    logic use_wait;
    send_event(OP_FRAME_START, advance_clock());
    renders = $urandom_range(1, 2);
    for (int r = 0; r < renders; r++) begin
      send_event(OP_RENDER_START, advance_clock());
      blocks = $urandom_range(0, 2);
      for (int b = 0; b < blocks; b++) begin
        use_wait = 1'($urandom_range(1));
        send_event(use_wait ? OP_WAIT_START : OP_FLUSH_START, advance_clock());
        send_event(use_wait ? OP_WAIT_END : OP_FLUSH_END, advance_clock());
      end
      // flush left open across the render end is not blocked time
      if ($urandom_range(3) == 0) begin
        send_event(OP_FLUSH_START, advance_clock());
        send_event(OP_RENDER_END, advance_clock());
        send_event(OP_FLUSH_END, advance_clock());
      end else begin
        send_event(OP_RENDER_END, advance_clock());
      end
    end
    send_event(OP_FRAME_END, advance_clock());
    if ($urandom_range(2) == 0) send_event(OP_REPORT, advance_clock());
  endtask

  // mix of frames, lone reports and random or broken events
  task automatic random_traffic(input int n_events, input int n_reports);
    int ev0;
    int rp0;
    int pick;
    ev0 = events_sent;
    rp0 = reports_sent;
    while (events_sent - ev0 < n_events || reports_sent - rp0 < n_reports) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame();
      end else if (pick < 80) begin
        send_event(OP_REPORT, advance_clock());
      end else begin
        repeat ($urandom_range(1, 4)) send_event(OP_W'($urandom_range(15)), noise_time());
      end
    end
  endtask

  // ignored events, unused opcodes and starts at time zero
  task automatic test_after_reset();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_event(OP_REPORT, 48'd0);
    send_event(OP_FRAME_END, 48'd100);
    send_event(OP_RENDER_END, 48'd110);
    send_event(OP_WAIT_END, 48'd130);
    send_event(OP_UNUSED_LO, 48'd140);
    send_event(OP_UNUSED_HI, 48'd150);
    send_event(OP_FRAME_START, 48'd0);
    send_event(OP_RENDER_START, 48'd200);
    send_event(OP_RENDER_START, 48'd250);
    send_event(OP_RENDER_END, 48'd300);
    send_event(OP_FRAME_END, 48'd400);
    send_event(OP_REPORT, 48'd500);
  endtask

  // flush and wait inside a render, and blocked time longer than the render
  task automatic test_render_overlap();
    send_event(OP_FRAME_START, 48'd1000);
    send_event(OP_RENDER_START, 48'd1200);
    send_event(OP_FLUSH_START, 48'd1250);
    send_event(OP_FLUSH_END, 48'd1300);
    send_event(OP_WAIT_START, 48'd1300);
    send_event(OP_WAIT_END, 48'd1400);
    send_event(OP_RENDER_END, 48'd1500);
    send_event(OP_FLUSH_START, 48'd1900);
    send_event(OP_RENDER_START, 48'd2000);
    send_event(OP_FLUSH_END, 48'd2100);
    send_event(OP_RENDER_END, 48'd2050);
    send_event(OP_FRAME_END, 48'd2200);
  endtask

  // times near the top of the range and timestamps running backward
  task automatic test_time_extremes();
    send_event(OP_FRAME_START, 48'hFFFF_FFFF_FF00);
    send_event(OP_FRAME_END, 48'h0000_0000_0100);
    send_event(OP_REPORT, 48'hFFFF_FFFF_FFFF);
    send_event(OP_REPORT, 48'h0000_0000_0001);
    now_us = 48'h0000_0001_0000;
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    random_traffic(100, 6);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 88;
    stall_pct     = 0;
    random_traffic(100, 6);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct     = 88;
    random_traffic(100, 6);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 15;
    stall_pct     = 15;
    random_traffic(100, 6);
  endtask

  initial begin
    reset_stats();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_render_overlap();
    test_time_extremes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2 * REPORT_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
